// ===== rtl/core/dfiir_pkg.sv =====
// Shared types, codes and helper functions of the direct-form IIR filter.
package dfiir_pkg;

   // Opcodes carried on the request channel.
   localparam int OPCODE_BITS = 2;
   localparam logic [OPCODE_BITS-1:0] OP_FILTER = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_LOAD_B = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_LOAD_A = 2'd2;

   // Control and status registers.
   localparam int NUM_B_BITS     = 7;
   localparam int NUM_A_BITS     = 6;
   localparam int CSR_DATA_BITS  = 7;
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_B_TAPS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_A_TAPS = 1'd1;
   localparam logic [NUM_B_BITS-1:0] NUM_B_RESET = 7'd3;
   localparam logic [NUM_A_BITS-1:0] NUM_A_RESET = 6'd1;

   // Fraction bits of a coefficient word.
   localparam int COEF_FRAC = 15;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FEEDFWD,
      ST_FEEDBACK,
      ST_DRAIN,
      ST_EMIT
   } seq_state_type;

   // Command to the multiply-accumulate unit, aligned with the memory read data.
   typedef struct packed {
      logic clear;
      logic valid;
      logic feedback;
      logic keep;
   } mac_cmd_type;

   typedef struct packed {
      logic busy;
   } mac_stat_type;

   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   function automatic int count_bits(input int max_b, input int max_a);
      return (max_b > max_a) ? $clog2(max_b + 1) : $clog2(max_a + 1);
   endfunction

endpackage

// ===== rtl/core/dfiir_req_if.sv =====
// Request channel of the IIR filter: samples and coefficient loads.
interface dfiir_req_if #(
   parameter int INDEX_BITS  = 6,
   parameter int COEFF_BITS  = 18,
   parameter int SAMPLE_BITS = 16
);
   import dfiir_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [OPCODE_BITS-1:0]        opcode;
   logic [INDEX_BITS-1:0]         coeff_index;
   logic signed [COEFF_BITS-1:0]  coeff_value;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                          clear_history;

   modport source (
      output valid, opcode, coeff_index, coeff_value, sample_in, clear_history,
      input  ready
   );

   modport sink (
      input  valid, opcode, coeff_index, coeff_value, sample_in, clear_history,
      output ready
   );

endinterface

// ===== rtl/core/dfiir_rsp_if.sv =====
// Response channel of the IIR filter: filtered samples.
interface dfiir_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;

   modport source (
      output valid, sample_out,
      input  ready
   );

   modport sink (
      input  valid, sample_out,
      output ready
   );

endinterface

// ===== rtl/core/direct_form_iir_filter.sv =====
// Top level of the direct-form-I IIR filter.
// A filter beat computes y[n] = sum b[k]x[n-k] - sum a[k]y[n-k] over the taps in use with one
// shared multiplier, one tap per cycle. No new request is taken until the result of the beat
// has moved to the response register; the next request is taken while that result still
// waits on the response channel. Coefficient loads give no response. Coefficients live in
// two RAMs that hold nothing until loaded; the histories live in RAM rings whose fill levels
// make entries read as zero after reset or after a beat with clear_history set, so no clearing
// pass is needed. Samples are signed Q1.15, coefficients signed with 15 fraction bits; the sum
// is rounded to nearest (ties upward) and saturated to the sample width.
module direct_form_iir_filter #(
   parameter int MAX_B_TAPS  = 64,
   parameter int MAX_A_TAPS  = 32,
   parameter int COEFF_BITS  = 18,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   dfiir_req_if.sink                            req,
   dfiir_rsp_if.source                          rsp,
   input  logic                                 csr_write_en,
   input  logic [dfiir_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dfiir_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import dfiir_pkg::*;

   localparam int XAW       = addr_bits(MAX_B_TAPS);
   localparam int YAW       = addr_bits(MAX_A_TAPS);
   localparam int CW        = count_bits(MAX_B_TAPS, MAX_A_TAPS);
   localparam int SUM_BITS  = COEFF_BITS + SAMPLE_BITS + $clog2(MAX_B_TAPS + MAX_A_TAPS) + 1;
   localparam int MIN_BITS  = SAMPLE_BITS + COEF_FRAC + 1;
   localparam int WIDE_BITS = (SUM_BITS > MIN_BITS) ? SUM_BITS : MIN_BITS;
   localparam int ACC_BITS  = (WIDE_BITS > 64) ? 64 : WIDE_BITS;

   logic [NUM_B_BITS-1:0] num_b_taps_ff;
   logic [NUM_A_BITS-1:0] num_a_taps_ff;
   logic [CW-1:0]         ff_count;
   logic [CW-1:0]         fb_count;

   logic           ffc_we, fbc_we, xh_we, yh_we;
   logic [XAW-1:0] ffc_waddr, ffc_raddr, xh_waddr, xh_raddr;
   logic [YAW-1:0] fbc_waddr, fbc_raddr, yh_waddr, yh_raddr;
   logic [COEFF_BITS-1:0]  ffc_rdata, fbc_rdata;
   logic [SAMPLE_BITS-1:0] xh_rdata, yh_rdata;

   mac_cmd_type  mac_cmd;
   mac_stat_type mac_stat;
   logic signed [SAMPLE_BITS-1:0] mac_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_b_taps_ff <= NUM_B_RESET;
         num_a_taps_ff <= NUM_A_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_NUM_B_TAPS: num_b_taps_ff <= csr_wdata[NUM_B_BITS-1:0];
            CSR_NUM_A_TAPS: num_a_taps_ff <= csr_wdata[NUM_A_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp the tap counts to the table sizes; the leading denominator tap is implicit.
   always_comb begin
      if (int'(num_b_taps_ff) > MAX_B_TAPS) begin
         ff_count = CW'(MAX_B_TAPS);
      end else begin
         ff_count = CW'(num_b_taps_ff);
      end
      if (int'(num_a_taps_ff) > MAX_A_TAPS) begin
         fb_count = CW'(MAX_A_TAPS - 1);
      end else if (num_a_taps_ff > NUM_A_BITS'(1)) begin
         fb_count = CW'(num_a_taps_ff - NUM_A_BITS'(1));
      end else begin
         fb_count = '0;
      end
   end

   dfiir_ram #(.WIDTH(COEFF_BITS), .DEPTH(MAX_B_TAPS)) u_ff_coef (
      .clock (clock),
      .we    (ffc_we),
      .waddr (ffc_waddr),
      .wdata (req.coeff_value),
      .raddr (ffc_raddr),
      .rdata (ffc_rdata)
   );

   dfiir_ram #(.WIDTH(COEFF_BITS), .DEPTH(MAX_A_TAPS)) u_fb_coef (
      .clock (clock),
      .we    (fbc_we),
      .waddr (fbc_waddr),
      .wdata (req.coeff_value),
      .raddr (fbc_raddr),
      .rdata (fbc_rdata)
   );

   dfiir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_B_TAPS)) u_x_hist (
      .clock (clock),
      .we    (xh_we),
      .waddr (xh_waddr),
      .wdata (req.sample_in),
      .raddr (xh_raddr),
      .rdata (xh_rdata)
   );

   dfiir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_A_TAPS)) u_y_hist (
      .clock (clock),
      .we    (yh_we),
      .waddr (yh_waddr),
      .wdata (mac_y),
      .raddr (yh_raddr),
      .rdata (yh_rdata)
   );

   dfiir_mac #(
      .COEFF_BITS  (COEFF_BITS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_BITS    (ACC_BITS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mac_cmd),
      .ff_coef (ffc_rdata),
      .fb_coef (fbc_rdata),
      .x_hist  (xh_rdata),
      .y_hist  (yh_rdata),
      .stat    (mac_stat),
      .y       (mac_y)
   );

   dfiir_ctrl #(
      .MAX_B_TAPS  (MAX_B_TAPS),
      .MAX_A_TAPS  (MAX_A_TAPS),
      .COEFF_BITS  (COEFF_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .ff_count  (ff_count),
      .fb_count  (fb_count),
      .ffc_we    (ffc_we),
      .ffc_waddr (ffc_waddr),
      .ffc_raddr (ffc_raddr),
      .fbc_we    (fbc_we),
      .fbc_waddr (fbc_waddr),
      .fbc_raddr (fbc_raddr),
      .xh_we     (xh_we),
      .xh_waddr  (xh_waddr),
      .xh_raddr  (xh_raddr),
      .yh_we     (yh_we),
      .yh_waddr  (yh_waddr),
      .yh_raddr  (yh_raddr),
      .mac_cmd   (mac_cmd),
      .mac_stat  (mac_stat),
      .mac_y     (mac_y)
   );

endmodule

// ===== rtl/core/dfiir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dfiir_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 64,
   localparam int AW = dfiir_pkg::addr_bits(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/dfiir_mac.sv =====
// Shared multiply-accumulate unit with rounding and saturation of the sum.
module dfiir_mac #(
   parameter int COEFF_BITS  = 18,
   parameter int SAMPLE_BITS = 16,
   parameter int ACC_BITS    = 42
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dfiir_pkg::mac_cmd_type        cmd,
   input  logic signed [COEFF_BITS-1:0]  ff_coef,
   input  logic signed [COEFF_BITS-1:0]  fb_coef,
   input  logic signed [SAMPLE_BITS-1:0] x_hist,
   input  logic signed [SAMPLE_BITS-1:0] y_hist,
   output dfiir_pkg::mac_stat_type       stat,
   output logic signed [SAMPLE_BITS-1:0] y
);
   import dfiir_pkg::*;

   localparam int PROD_BITS = COEFF_BITS + SAMPLE_BITS;
   localparam logic signed [ACC_BITS-1:0] ROUND_BIAS = ACC_BITS'(1) << (COEF_FRAC - 1);
   localparam logic signed [ACC_BITS-1:0] SMAX =
      {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] SMIN =
      {{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [COEFF_BITS-1:0]  coef_sel;
   logic signed [SAMPLE_BITS-1:0] smp_sel;
   logic signed [PROD_BITS-1:0]   prod_in;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic                          valid_ff;
   logic                          neg_ff;
   logic signed [ACC_BITS-1:0]    acc_ff;
   logic signed [ACC_BITS-1:0]    acc_in;
   logic signed [ACC_BITS-1:0]    rounded;
   logic signed [ACC_BITS-1:0]    shifted;

   // A history word that was never written since the last clear counts as zero.
   always_comb begin
      coef_sel = cmd.feedback ? fb_coef : ff_coef;
      if (!cmd.keep) begin
         smp_sel = '0;
      end else if (cmd.feedback) begin
         smp_sel = y_hist;
      end else begin
         smp_sel = x_hist;
      end
      prod_in = coef_sel * smp_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= cmd.feedback;
      acc_ff  <= acc_in;
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.clear) begin
         acc_in = '0;
      end else if (valid_ff) begin
         if (neg_ff) begin
            acc_in = acc_ff - ACC_BITS'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_BITS'(prod_ff);
         end
      end
   end

   always_comb begin
      rounded = acc_ff + ROUND_BIAS;
      shifted = rounded >>> COEF_FRAC;
      priority if (shifted > SMAX) begin
         y = SMAX[SAMPLE_BITS-1:0];
      end else if (shifted < SMIN) begin
         y = SMIN[SAMPLE_BITS-1:0];
      end else begin
         y = shifted[SAMPLE_BITS-1:0];
      end
   end

   assign stat.busy = cmd.valid | cmd.clear | valid_ff;

endmodule

// ===== rtl/core/dfiir_ctrl.sv =====
// Sequencer of the IIR filter: handshakes, history rings and tap addressing.
module dfiir_ctrl #(
   parameter int MAX_B_TAPS  = 64,
   parameter int MAX_A_TAPS  = 32,
   parameter int COEFF_BITS  = 18,
   parameter int SAMPLE_BITS = 16,
   localparam int XAW = dfiir_pkg::addr_bits(MAX_B_TAPS),
   localparam int YAW = dfiir_pkg::addr_bits(MAX_A_TAPS),
   localparam int CW  = dfiir_pkg::count_bits(MAX_B_TAPS, MAX_A_TAPS)
) (
   input  logic                          clock,
   input  logic                          reset,
   dfiir_req_if.sink                     req,
   dfiir_rsp_if.source                   rsp,
   input  logic [CW-1:0]                 ff_count,
   input  logic [CW-1:0]                 fb_count,
   output logic                          ffc_we,
   output logic [XAW-1:0]                ffc_waddr,
   output logic [XAW-1:0]                ffc_raddr,
   output logic                          fbc_we,
   output logic [YAW-1:0]                fbc_waddr,
   output logic [YAW-1:0]                fbc_raddr,
   output logic                          xh_we,
   output logic [XAW-1:0]                xh_waddr,
   output logic [XAW-1:0]                xh_raddr,
   output logic                          yh_we,
   output logic [YAW-1:0]                yh_waddr,
   output logic [YAW-1:0]                yh_raddr,
   output dfiir_pkg::mac_cmd_type        mac_cmd,
   input  dfiir_pkg::mac_stat_type       mac_stat,
   input  logic signed [SAMPLE_BITS-1:0] mac_y
);
   import dfiir_pkg::*;

   seq_state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [XAW-1:0] xptr_ff, xptr_in;
   logic [CW-1:0]  xfill_ff, xfill_in;
   logic [XAW-1:0] xaddr_ff, xaddr_in;
   logic [YAW-1:0] yptr_ff, yptr_in;
   logic [CW-1:0]  yfill_ff, yfill_in;
   logic [YAW-1:0] yaddr_ff, yaddr_in;
   mac_cmd_type    cmd_ff, cmd_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff;

   logic req_fire;
   logic sample_fire;
   logic emit_fire;
   logic ff_last;
   logic fb_last;
   logic [XAW-1:0] xptr_next;
   logic [YAW-1:0] yptr_next;

   assign req_fire    = req.valid & req.ready;
   assign sample_fire = req_fire & (req.opcode == OP_FILTER);
   assign emit_fire   = (state_ff == ST_EMIT) & (~rsp_valid_ff | rsp.ready);
   assign ff_last     = (cnt_ff == ff_count - CW'(1));
   assign fb_last     = (cnt_ff == fb_count - CW'(1));

   // A clear restarts the input ring so that the new sample lands at position one.
   always_comb begin
      if (req.clear_history) begin
         xptr_next = XAW'(1);
      end else if (xptr_ff == XAW'(MAX_B_TAPS - 1)) begin
         xptr_next = '0;
      end else begin
         xptr_next = xptr_ff + XAW'(1);
      end
      if (yptr_ff == YAW'(MAX_A_TAPS - 1)) begin
         yptr_next = '0;
      end else begin
         yptr_next = yptr_ff + YAW'(1);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (sample_fire) begin
               if (ff_count != '0) begin
                  state_in = ST_FEEDFWD;
               end else if (fb_count != '0) begin
                  state_in = ST_FEEDBACK;
               end else begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_FEEDFWD: begin
            if (ff_last) begin
               state_in = (fb_count != '0) ? ST_FEEDBACK : ST_DRAIN;
            end
         end
         ST_FEEDBACK: begin
            if (fb_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!mac_stat.busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req.ready       = (state_ff == ST_IDLE);
      cmd_in.clear    = sample_fire;
      cmd_in.valid    = (state_ff == ST_FEEDFWD) | (state_ff == ST_FEEDBACK);
      cmd_in.feedback = (state_ff == ST_FEEDBACK);
      cmd_in.keep     = (state_ff == ST_FEEDBACK) ? (cnt_ff < yfill_ff) : (cnt_ff < xfill_ff);

      ffc_we    = req_fire & (req.opcode == OP_LOAD_B) & (int'(req.coeff_index) < MAX_B_TAPS);
      ffc_waddr = XAW'(req.coeff_index);
      ffc_raddr = cnt_ff[XAW-1:0];
      fbc_we    = req_fire & (req.opcode == OP_LOAD_A) & (int'(req.coeff_index) < MAX_A_TAPS);
      fbc_waddr = YAW'(req.coeff_index);
      fbc_raddr = YAW'(cnt_ff + CW'(1));
      xh_we     = sample_fire;
      xh_waddr  = xptr_next;
      xh_raddr  = xaddr_ff;
      yh_we     = emit_fire;
      yh_waddr  = yptr_next;
      yh_raddr  = yaddr_ff;
   end

   // Counters, ring pointers and fill levels.
   always_comb begin
      cnt_in       = cnt_ff;
      xptr_in      = xptr_ff;
      xfill_in     = xfill_ff;
      xaddr_in     = xaddr_ff;
      yptr_in      = yptr_ff;
      yfill_in     = yfill_ff;
      yaddr_in     = yaddr_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp.valid && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (sample_fire) begin
               xptr_in  = xptr_next;
               xaddr_in = xptr_next;
               yaddr_in = yptr_ff;
               if (req.clear_history) begin
                  xfill_in = CW'(1);
                  yfill_in = '0;
               end else if (xfill_ff != CW'(MAX_B_TAPS)) begin
                  xfill_in = xfill_ff + CW'(1);
               end
            end
         end
         ST_FEEDFWD: begin
            cnt_in   = ff_last ? '0 : cnt_ff + CW'(1);
            xaddr_in = (xaddr_ff == '0) ? XAW'(MAX_B_TAPS - 1) : xaddr_ff - XAW'(1);
         end
         ST_FEEDBACK: begin
            cnt_in   = cnt_ff + CW'(1);
            yaddr_in = (yaddr_ff == '0) ? YAW'(MAX_A_TAPS - 1) : yaddr_ff - YAW'(1);
         end
         ST_DRAIN: begin
            cnt_in = '0;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in = 1'b1;
               yptr_in      = yptr_next;
               if (yfill_ff != CW'(MAX_A_TAPS)) begin
                  yfill_in = yfill_ff + CW'(1);
               end
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         xptr_ff      <= '0;
         xfill_ff     <= '0;
         xaddr_ff     <= '0;
         yptr_ff      <= '0;
         yfill_ff     <= '0;
         yaddr_ff     <= '0;
         cmd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         xptr_ff      <= xptr_in;
         xfill_ff     <= xfill_in;
         xaddr_ff     <= xaddr_in;
         yptr_ff      <= yptr_in;
         yfill_ff     <= yfill_in;
         yaddr_ff     <= yaddr_in;
         cmd_ff       <= cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_data_ff <= mac_y;
      end
   end

   assign mac_cmd        = cmd_ff;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = rsp_data_ff;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the direct-form-I IIR filter, with a built-in fixed-point predictor.
`timescale 1ns / 100ps

module testbench;
   import dfiir_pkg::*;

   localparam int FF_DEPTH = 64;
   localparam int FB_DEPTH = 32;
   localparam int COEF_W = 18;
   localparam int SAMP_W = 16;
   localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int ITEMS_PER_PHASE = 155;
   localparam int NUM_PHASES = 8;
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_AFTER = 150;
   localparam int HOLD_CYCLES = 600;

   typedef struct {
      logic [OPCODE_BITS-1:0]    opcode;
      logic [5:0]                coeff_idx;
      logic signed [COEF_W-1:0]  coeff_val;
      logic signed [SAMP_W-1:0]  sample;
      logic                      clear;
   } filter_req_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   dfiir_req_if #(.INDEX_BITS(6), .COEFF_BITS(COEF_W), .SAMPLE_BITS(SAMP_W)) req_if ();
   dfiir_rsp_if #(.SAMPLE_BITS(SAMP_W)) rsp_if ();

   direct_form_iir_filter u_dut (
      .clock        (clock),
      .reset        (reset),
      .req          (req_if),
      .rsp          (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Predictor state: coefficient tables, both history rings and the tap counts.
   logic signed [COEF_W-1:0] ff_coef [FF_DEPTH];
   logic signed [COEF_W-1:0] fb_coef [FB_DEPTH];
   logic signed [SAMP_W-1:0] x_hist [FF_DEPTH];
   logic signed [SAMP_W-1:0] y_hist [FB_DEPTH];
   logic [5:0] x_ptr;
   logic [NUM_B_BITS-1:0] cfg_num_b;
   logic [NUM_A_BITS-1:0] cfg_num_a;

   filter_req_type pending_reqs [$];
   logic signed [SAMP_W-1:0] expected_samples [$];
   int mismatches;
   int samples_checked;
   int tx_idle_pct;
   int rx_idle_pct;
   int hold_left;
   bit hold_done;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Applies one accepted beat to the predictor; a filter beat yields one expected sample.
   task automatic filter_request(input filter_req_type r);
      longint acc;
      int nb;
      int na;
      logic [5:0] pos;
      logic signed [SAMP_W-1:0] y;
      case (r.opcode)
         OP_LOAD_B: ff_coef[r.coeff_idx] = r.coeff_val;
         OP_LOAD_A: if (r.coeff_idx < FB_DEPTH) fb_coef[r.coeff_idx[4:0]] = r.coeff_val;
         OP_FILTER: begin
            if (r.clear) begin
               foreach (x_hist[i]) x_hist[i] = '0;
               foreach (y_hist[i]) y_hist[i] = '0;
               x_ptr = '0;
            end
            x_ptr = x_ptr + 6'd1;
            x_hist[x_ptr] = r.sample;
            nb = (cfg_num_b > FF_DEPTH) ? FF_DEPTH : int'(cfg_num_b);
            na = (cfg_num_a > FB_DEPTH) ? FB_DEPTH : int'(cfg_num_a);
            acc = 0;
            for (int k = 0; k < nb; k++) begin
               pos = x_ptr - 6'(k);
               acc += longint'(ff_coef[k]) * longint'(x_hist[pos]);
            end
            for (int k = 1; k < na; k++)
               acc -= longint'(fb_coef[k]) * longint'(y_hist[k-1]);
            acc = (acc + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
            if (acc > 32767)
               y = 16'sh7FFF;
            else if (acc < -32768)
               y = 16'sh8000;
            else
               y = acc[SAMP_W-1:0];
            for (int k = FB_DEPTH - 1; k > 0; k--)
               y_hist[k] = y_hist[k-1];
            y_hist[0] = y;
            expected_samples.push_back(y);
         end
         default: ;
      endcase
   endtask

   task automatic queue_request(input logic [OPCODE_BITS-1:0] op, input int idx,
                                input logic signed [COEF_W-1:0] val,
                                input logic signed [SAMP_W-1:0] smp, input logic clr);
      filter_req_type r;
      r.opcode = op;
      r.coeff_idx = 6'(idx);
      r.coeff_val = val;
      r.sample = smp;
      r.clear = clr;
      pending_reqs.push_back(r);
   endtask

   // Scaled-down words keep part of the outputs out of saturation.
   function automatic logic signed [COEF_W-1:0] random_coeff(input int max_shift);
      logic signed [COEF_W-1:0] raw;
      raw = COEF_W'($urandom);
      return raw >>> $urandom_range(max_shift);
   endfunction

   function automatic logic signed [SAMP_W-1:0] random_sample();
      logic signed [SAMP_W-1:0] raw;
      raw = SAMP_W'($urandom);
      return raw >>> $urandom_range(4);
   endfunction

   function automatic filter_req_type random_request();
      filter_req_type r;
      int pick;
      pick = $urandom_range(99);
      r.coeff_idx = 6'($urandom);
      r.coeff_val = random_coeff(8);
      r.sample = random_sample();
      r.clear = 1'($urandom);
      if (pick < 72) begin
         r.opcode = OP_FILTER;
         r.clear = ($urandom_range(49) == 0);
      end else if (pick < 86) begin
         r.opcode = OP_LOAD_B;
         r.coeff_val = random_coeff(6);
      end else if (pick < 97) begin
         r.opcode = OP_LOAD_A;
         r.coeff_val = random_coeff(12);
         // Mostly in range; the rest takes any index and can land beyond the feedback table.
         if ($urandom_range(3) != 0) r.coeff_idx = 6'($urandom_range(FB_DEPTH - 1));
      end else begin
         r.opcode = OP_UNUSED;
      end
      return r;
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_NUM_B_TAPS)
         cfg_num_b = data[NUM_B_BITS-1:0];
      else
         cfg_num_a = data[NUM_A_BITS-1:0];
   endtask

   // Waits until every beat is taken and every result is back, then lets the block settle.
   task automatic wait_until_idle();
      while (pending_reqs.size() != 0 || req_if.valid || expected_samples.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Request driver: a beat stays on the channel until it is taken.
   always @(posedge clock) begin
      filter_req_type next_req;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            next_req = pending_reqs.pop_front();
            req_if.valid <= 1'b1;
            req_if.opcode <= next_req.opcode;
            req_if.coeff_index <= next_req.coeff_idx;
            req_if.coeff_value <= next_req.coeff_val;
            req_if.sample_in <= next_req.sample;
            req_if.clear_history <= next_req.clear;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Every accepted request beat goes through the predictor.
   always @(posedge clock) begin
      filter_req_type seen;
      if (!reset && req_if.valid && req_if.ready) begin
         seen.opcode = req_if.opcode;
         seen.coeff_idx = req_if.coeff_index;
         seen.coeff_val = req_if.coeff_value;
         seen.sample = req_if.sample_in;
         seen.clear = req_if.clear_history;
         filter_request(seen);
      end
   end

   // One long hold-off on the response side, so the block backs up into its input.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && samples_checked == HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      logic signed [SAMP_W-1:0] want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         samples_checked <= samples_checked + 1;
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected sample_out %0d", rsp_if.sample_out));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_if.sample_out !== want)
               report_mismatch($sformatf("sample_out %0d, expected %0d",
                                         rsp_if.sample_out, want));
         end
      end
   end

   initial begin
      int tap_b [NUM_PHASES];
      int tap_a [NUM_PHASES];
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.opcode = OP_FILTER;
      req_if.coeff_index = '0;
      req_if.coeff_value = '0;
      req_if.sample_in = '0;
      req_if.clear_history = 1'b0;
      rsp_if.ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_NUM_B_TAPS;
      csr_wdata = '0;
      tx_idle_pct = 30;
      rx_idle_pct = 30;
      cfg_num_b = NUM_B_RESET;
      cfg_num_a = NUM_A_RESET;
      x_ptr = '0;
      foreach (x_hist[i]) x_hist[i] = '0;
      foreach (y_hist[i]) y_hist[i] = '0;
      foreach (ff_coef[i]) ff_coef[i] = '0;
      foreach (fb_coef[i]) fb_coef[i] = '0;
      tap_b = '{64, 0, 127, 1, 8, 0, 65, 2};
      tap_a = '{32, 0, 127, 1, 4, 0, 33, 2};
      tap_b[5] = $urandom_range(1, FF_DEPTH);
      tap_a[5] = $urandom_range(1, FB_DEPTH);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Fill both tables so that no tap count ever reads an unloaded coefficient.
      for (int k = 0; k < FF_DEPTH; k++)
         queue_request(OP_LOAD_B, k, random_coeff(6), random_sample(), 1'($urandom));
      for (int k = 0; k < FB_DEPTH; k++)
         queue_request(OP_LOAD_A, k, random_coeff(12), random_sample(), 1'($urandom));

      // Directed part at the reset tap counts: three feedforward taps, no feedback.
      queue_request(OP_LOAD_B, 0, 18'sh1FFFF, 16'sh7FFF, 1'b1);
      queue_request(OP_LOAD_B, 1, 18'sh20000, 16'sh8000, 1'b0);
      queue_request(OP_LOAD_B, 2, 18'sh08000, 16'sh0000, 1'b0);
      queue_request(OP_FILTER, 63, 18'sh1FFFF, 16'sh7FFF, 1'b0);
      queue_request(OP_FILTER, 0, 18'sh20000, 16'sh8000, 1'b0);
      queue_request(OP_FILTER, 0, '0, 16'sh0000, 1'b0);
      queue_request(OP_FILTER, 0, '0, -16'sd1, 1'b0);
      queue_request(OP_FILTER, 0, '0, 16'sd1, 1'b1);
      queue_request(OP_UNUSED, 63, 18'sh3FFFF, 16'sd5, 1'b1);
      queue_request(OP_FILTER, 0, '0, 16'sd100, 1'b0);
      queue_request(OP_LOAD_A, 40, -18'sd1, '0, 1'b0);
      queue_request(OP_LOAD_A, 0, 18'sd12345, '0, 1'b0);
      queue_request(OP_LOAD_B, 63, -18'sd1, '0, 1'b1);
      queue_request(OP_FILTER, 0, '0, 16'sh8000, 1'b1);
      queue_request(OP_FILTER, 0, '0, 16'sh7FFF, 1'b0);
      wait_until_idle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_csr(CSR_NUM_B_TAPS, CSR_DATA_BITS'(tap_b[p]));
         write_csr(CSR_NUM_A_TAPS, CSR_DATA_BITS'(tap_a[p]));
         // One phase runs with both sides busy on every cycle.
         tx_idle_pct <= (p == 4) ? 0 : 30;
         rx_idle_pct <= (p == 4) ? 0 : 30;
         repeat (ITEMS_PER_PHASE) pending_reqs.push_back(random_request());
         wait_until_idle();
      end

      if (mismatches == 0 && expected_samples.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
